// ----- sv/ptw_pkg.sv -----
package ptw_pkg;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int CNT_W   = 37;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int PFN_W   = 40;
    localparam int OFF_W   = 12;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [PFN_W-1:0]   pfn_t;

    localparam logic [1:0] FUNC_MAP   = 2'd0;
    localparam logic [1:0] FUNC_UNMAP = 2'd1;
    localparam logic [1:0] FUNC_XLATE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd2;

    localparam logic [2:0] LINK_FLAGS = 3'b111;
    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

endpackage

// ----- sv/ptw_mem.sv -----
module ptw_mem
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 64,
    parameter int AW           = $clog2(TABLE_FRAMES) + IDX_W
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  entry_t        wdata,
    output entry_t        rdata
);

    localparam int DEPTH = TABLE_FRAMES * 512;

    entry_t mem [0:DEPTH-1];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ptw_walk.sv -----
module ptw_walk
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 64,
    parameter int FW           = $clog2(TABLE_FRAMES),
    parameter int AW           = FW + IDX_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [VA_W-1:0]  s_virt_addr,
    input  logic [PA_W-1:0]  s_phys_addr,
    input  logic             s_writable,
    input  logic             s_user_access,
    input  logic             s_no_exec,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_ok,
    output logic [1:0]       m_status,
    output logic [PA_W-1:0]  m_phys_out,
    output logic [CNT_W-1:0] m_page_count,
    input  pfn_t             pool_pfn,
    output logic             mem_we,
    output logic [AW-1:0]    mem_addr,
    output entry_t           mem_wdata,
    input  entry_t           mem_rdata
);

    localparam int DEPTH = TABLE_FRAMES * 512;
    localparam int NF_W  = $clog2(TABLE_FRAMES + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       lv_reg, lv_next;
    logic [FW-1:0]    cur_reg, cur_next;
    logic [NF_W-1:0]  next_free_reg, next_free_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             m_valid_reg, m_valid_next;

    logic [1:0]       func_reg;
    logic [VA_W-1:0]  va_reg;
    logic [PA_W-1:0]  pa_reg;
    logic             rw_reg, us_reg, nx_reg;
    logic             res_ok_reg, res_ok_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [PA_W-1:0]  res_pout_reg, res_pout_next;
    logic             m_ok_reg;
    logic [1:0]       m_status_reg;
    logic [PA_W-1:0]  m_phys_out_reg;
    logic [CNT_W-1:0] m_page_count_reg;

    logic [IDX_W-1:0] idx;
    logic [PFN_W:0]   link_diff;
    logic             link_in_pool;
    pfn_t             new_pfn;
    logic             accept;
    logic             out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        case (lv_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign link_diff    = {1'b0, mem_rdata[PA_W-1:OFF_W]} - {1'b0, pool_pfn};
    assign link_in_pool = !link_diff[PFN_W] &&
                          (link_diff[PFN_W-1:0] < PFN_W'(TABLE_FRAMES));
    assign new_pfn      = pool_pfn + PFN_W'(next_free_reg);

    always_comb begin
        state_next      = state_reg;
        lv_next         = lv_reg;
        cur_next        = cur_reg;
        next_free_next  = next_free_reg;
        count_next      = count_reg;
        clr_addr_next   = clr_addr_reg;
        m_valid_next    = m_valid_reg;
        res_ok_next     = res_ok_reg;
        res_status_next = res_status_reg;
        res_pout_next   = res_pout_reg;
        mem_we          = 1'b0;
        mem_addr        = {cur_reg, idx};
        mem_wdata       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    lv_next         = 2'd0;
                    cur_next        = '0;
                    res_ok_next     = 1'b0;
                    res_status_next = STATUS_UNMAPPED;
                    res_pout_next   = '0;
                    if (s_func == FUNC_MAP || s_func == FUNC_UNMAP ||
                        s_func == FUNC_XLATE) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (lv_reg != LEAF_LEVEL) begin
                    if (mem_rdata[0]) begin
                        if (link_in_pool) begin
                            cur_next   = link_diff[FW-1:0];
                            lv_next    = lv_reg + 2'd1;
                            state_next = ST_READ;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end else if (func_reg != FUNC_MAP) begin
                        state_next = ST_RESULT;
                    end else if (next_free_reg >= NF_W'(TABLE_FRAMES)) begin
                        res_status_next = STATUS_NO_FRAME;
                        state_next      = ST_RESULT;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wdata      = {12'd0, new_pfn, 9'd0, LINK_FLAGS};
                        cur_next       = next_free_reg[FW-1:0];
                        next_free_next = next_free_reg + NF_W'(1);
                        lv_next        = lv_reg + 2'd1;
                        state_next     = ST_READ;
                    end
                end else begin
                    state_next = ST_RESULT;
                    case (func_reg)
                        FUNC_MAP: begin
                            mem_we          = 1'b1;
                            mem_wdata       = {nx_reg, 11'd0, pa_reg[PA_W-1:OFF_W], 9'd0,
                                               us_reg, rw_reg, 1'b1};
                            res_ok_next     = 1'b1;
                            res_status_next = STATUS_DONE;
                            if (!mem_rdata[0] && count_reg != COUNT_MAX) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_UNMAP: begin
                            if (mem_rdata[0]) begin
                                mem_we          = 1'b1;
                                res_ok_next     = 1'b1;
                                res_status_next = STATUS_DONE;
                                if (count_reg != '0) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            if (mem_rdata[0]) begin
                                res_ok_next     = 1'b1;
                                res_status_next = STATUS_DONE;
                                res_pout_next   = {mem_rdata[PA_W-1:OFF_W],
                                                   va_reg[OFF_W-1:0]};
                            end
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            lv_reg        <= '0;
            cur_reg       <= '0;
            next_free_reg <= NF_W'(1);
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lv_reg        <= lv_next;
            cur_reg       <= cur_next;
            next_free_reg <= next_free_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            va_reg   <= s_virt_addr;
            pa_reg   <= s_phys_addr;
            rw_reg   <= s_writable;
            us_reg   <= s_user_access;
            nx_reg   <= s_no_exec;
        end
        res_ok_reg     <= res_ok_next;
        res_status_reg <= res_status_next;
        res_pout_reg   <= res_pout_next;
        if (state_reg == ST_RESULT && out_free) begin
            m_ok_reg         <= res_ok_reg;
            m_status_reg     <= res_status_reg;
            m_phys_out_reg   <= res_pout_reg;
            m_page_count_reg <= count_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_status     = m_status_reg;
    assign m_phys_out   = m_phys_out_reg;
    assign m_page_count = m_page_count_reg;

endmodule

// ----- sv/four_level_page_table_engine_top.sv -----
// Four-level page table engine with an internal pool of table frames.
// Input channel s_*: one map, unmap or translate request per item.
// Result channel m_*: exactly one result item per request, in order.
// cfg_we/cfg_wdata write pool_base; write it only while no request is open.
// A request walks up to four levels; each level passes through a table read
// state and an evaluate state on the single-port table memory, with link or
// leaf writes folded into the evaluate state. A request with func 3 skips the
// walk and goes straight to the result state.
// One request is in flight at a time; s_ready rises again once the result
// sits in the output register, even if m_ready is low.
// When the receiver stalls, the result holds on m_* and the next request
// waits before its result stage until the output register empties.
// Reset: aresetn is synchronous, active low. After reset the block sweeps all
// TABLE_FRAMES * 512 table entries (32768 at the default) to zero, one entry
// per cycle, with s_ready low; cfg writes are taken meanwhile.
module four_level_page_table_engine_top
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [PA_W-1:0]  cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [VA_W-1:0]  s_virt_addr,
    input  logic [PA_W-1:0]  s_phys_addr,
    input  logic             s_writable,
    input  logic             s_user_access,
    input  logic             s_no_exec,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_ok,
    output logic [1:0]       m_status,
    output logic [PA_W-1:0]  m_phys_out,
    output logic [CNT_W-1:0] m_page_count
);

    localparam int FW = $clog2(TABLE_FRAMES);
    localparam int AW = FW + IDX_W;

    logic [PA_W-1:0] pool_base_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    entry_t          mem_wdata;
    entry_t          mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
        end else if (cfg_we) begin
            pool_base_reg <= cfg_wdata;
        end
    end

    ptw_mem #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .AW           (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    ptw_walk #(
        .TABLE_FRAMES (TABLE_FRAMES),
        .FW           (FW),
        .AW           (AW)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_virt_addr   (s_virt_addr),
        .s_phys_addr   (s_phys_addr),
        .s_writable    (s_writable),
        .s_user_access (s_user_access),
        .s_no_exec     (s_no_exec),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_status      (m_status),
        .m_phys_out    (m_phys_out),
        .m_page_count  (m_page_count),
        .pool_pfn      (pool_base_reg[PA_W-1:OFF_W]),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

endmodule
